FILE: rtl/rgbc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and pipeline stage map of the rgbc color temperature classifier
// no dependencies

package rgbc_pkg;

  // default configuration
  localparam int unsigned SENSORS_DEF    = 8;
  localparam int unsigned GAMMA_BITS_DEF = 10;

  // threshold words per sensor
  localparam int unsigned SLOTS = 6;

  // request opcodes
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // threshold slots
  localparam logic [2:0] SLOT_MID_MAX    = 3'd0;
  localparam logic [2:0] SLOT_MID_MIN    = 3'd1;
  localparam logic [2:0] SLOT_WHITE_MAX  = 3'd2;
  localparam logic [2:0] SLOT_WHITE_MIN  = 3'd3;
  localparam logic [2:0] SLOT_YELLOW_MAX = 3'd4;
  localparam logic [2:0] SLOT_YELLOW_MIN = 3'd5;

  // result classes
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_MID    = 2'd1;
  localparam logic [1:0] CLS_WHITE  = 2'd2;
  localparam logic [1:0] CLS_YELLOW = 2'd3;

  // divider shape: quotient bits per pipeline stage
  localparam int unsigned DIV_SPS   = 2;
  localparam int unsigned RATIO_QW  = 16;
  localparam int unsigned XY_QW     = 16;
  localparam int unsigned MC_QW     = 21;
  localparam int unsigned RATIO_NS  = (RATIO_QW + DIV_SPS - 1) / DIV_SPS;
  localparam int unsigned XY_NS     = (XY_QW + DIV_SPS - 1) / DIV_SPS;
  localparam int unsigned MC_NS     = (MC_QW + DIV_SPS - 1) / DIV_SPS;

  // stage map
  localparam int unsigned XYZ_TOT = 2 + XY_NS;
  localparam int unsigned MC_TOT  = MC_NS + 6;
  localparam int unsigned ST_GAM  = RATIO_NS;
  localparam int unsigned ST_XYZ  = ST_GAM + 2;
  localparam int unsigned ST_MC   = ST_XYZ + XYZ_TOT;
  localparam int unsigned ST_OUT  = ST_MC + MC_TOT;
  localparam int unsigned NST     = ST_OUT + 1;

  localparam int unsigned ACC_W = 40;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  sensor_index;
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;
    logic [15:0] clear_count;
    logic [2:0]  threshold_slot;
    logic [15:0] threshold_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cct_kelvin;
    logic [1:0]  color_class;
    logic        math_error;
  } out_item_t;

  // threshold table access from the pipeline
  typedef struct packed {
    logic        wr;
    logic [2:0]  sensor;
    logic [2:0]  slot;
    logic [15:0] value;
  } thr_req_t;

endpackage

FILE: rtl/rgbc_div_pipe.sv
`timescale 1ns / 1ps
// pipelined restoring divider, a few quotient bits per stage
// no package dependencies

module rgbc_div_pipe #(
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SPS = 2,
  localparam int unsigned NSTG = (QW + SPS - 1) / SPS
) (
  input  logic            clk,
  input  logic [NSTG-1:0] en,
  input  logic [DW-1:0]   rem_in,   // must be below div_in
  input  logic [QW-1:0]   bits_in,  // dividend bits shifted in msb first
  input  logic [DW-1:0]   div_in,
  output logic [QW-1:0]   quo_out
);

  logic [DW-1:0] rem_r [NSTG];
  logic [QW-1:0] sh_r  [NSTG];
  logic [DW-1:0] d_r   [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    localparam int unsigned NSTEP = ((QW - g * SPS) < SPS) ? (QW - g * SPS) : SPS;
    logic [DW-1:0] rem_src, d_src, rem_nxt;
    logic [QW-1:0] sh_src, sh_nxt;

    if (g == 0) begin : g_first
      assign rem_src = rem_in;
      assign sh_src  = bits_in;
      assign d_src   = div_in;
    end else begin : g_next
      assign rem_src = rem_r[g-1];
      assign sh_src  = sh_r[g-1];
      assign d_src   = d_r[g-1];
    end

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] s;
      r = rem_src;
      s = sh_src;
      for (int k = 0; k < NSTEP; k++) begin
        t = {r, s[QW-1]};
        s = {s[QW-2:0], 1'b0};
        if (t >= {1'b0, d_src}) begin
          t    = t - {1'b0, d_src};
          s[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
      rem_nxt = r;
      sh_nxt  = s;
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_r[g] <= rem_nxt;
        sh_r[g]  <= sh_nxt;
        d_r[g]   <= d_src;
      end
    end
  end

  assign quo_out = sh_r[NSTG-1];

endmodule

FILE: rtl/rgbc_gamma.sv
`timescale 1ns / 1ps
// srgb to linear conversion: gamma rom read and linear interpolation, two stages
// no package dependencies

module rgbc_gamma #(
  parameter int unsigned GAMMA_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic        sat,    // ratio reached 1.0
  input  logic [15:0] ratio,
  output logic [16:0] lin
);

  localparam int unsigned GB     = GAMMA_TABLE_BITS;
  localparam int unsigned K      = 16 - GB;
  localparam int unsigned GSTEPS = 1 << GB;
  localparam int unsigned MW     = 19 + K;

  typedef logic [16:0] rom_t [0:GSTEPS];

  function automatic logic [16:0] gpoint(longint unsigned s);
    longint unsigned t, t2, lo, hi, mid, p;
    if (s * 100000 <= 4045 * 65536) begin
      return 17'((s * 100) / 1292);
    end
    t  = (s * 1000 + 55 * 65536) / 1055;
    t2 = (t * t) >> 16;
    lo = 0;
    hi = 65536;
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        p   = mid;
        for (int k = 0; k < 4; k++) p = (p * mid) >> 16;
        if (p <= t2) lo = mid;
        else hi = mid - 1;
      end
    end
    return 17'((t2 * lo) >> 16);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= GSTEPS; i++) r[i] = gpoint(longint'(i) << K);
    return r;
  endfunction

  localparam rom_t GAMMA_ROM = build_rom();

  logic [GB:0]   idx0, idx1;
  logic [16:0]   g0_r, g1_r, lin_r, lin_nxt;
  logic [K-1:0]  f_r;
  logic          sat_r;
  logic [K:0]    w0;
  logic [MW-1:0] mix;

  assign idx0 = {1'b0, ratio[15:K]};
  assign idx1 = idx0 + 1'b1;

  // rom read
  always_ff @(posedge clk) begin
    if (en[0]) begin
      g0_r  <= GAMMA_ROM[idx0];
      g1_r  <= GAMMA_ROM[idx1];
      f_r   <= ratio[K-1:0];
      sat_r <= sat;
    end
  end

  // interpolate between neighboring entries
  assign w0  = {1'b1, {K{1'b0}}} - {1'b0, f_r};
  assign mix = MW'(g0_r) * MW'(w0) + MW'(g1_r) * MW'(f_r);
  assign lin_nxt = sat_r ? 17'h10000 : mix[K+16:K];

  always_ff @(posedge clk) begin
    if (en[1]) lin_r <= lin_nxt;
  end

  assign lin = lin_r;

endmodule

FILE: rtl/rgbc_xyz.sv
`timescale 1ns / 1ps
// srgb to xyz matrix and xy chromaticity dividers
// depends on rgbc_pkg and rgbc_div_pipe

module rgbc_xyz (
  input  logic                         clk,
  input  logic [rgbc_pkg::XYZ_TOT-1:0] en,
  input  logic [2:0][16:0]             lin,  // red, green, blue
  output logic                         sum_zero,
  output logic [15:0]                  xq,
  output logic [15:0]                  yq
);

  import rgbc_pkg::*;

  localparam logic [15:0] COEF [3][3] = '{
    '{16'd27031, 16'd23434, 16'd11825},
    '{16'd13938, 16'd46868, 16'd4730},
    '{16'd1267,  16'd7811,  16'd62279}
  };

  logic [32:0] prod_r [3][3];
  logic [33:0] bx_r, by_r, sum_r, bx_nxt, by_nxt, bz_nxt;

  // products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= 33'(lin[c]) * 33'(COEF[r][c]);
        end
      end
    end
  end

  // row sums and chromaticity denominator
  assign bx_nxt = 34'(prod_r[0][0]) + 34'(prod_r[0][1]) + 34'(prod_r[0][2]);
  assign by_nxt = 34'(prod_r[1][0]) + 34'(prod_r[1][1]) + 34'(prod_r[1][2]);
  assign bz_nxt = 34'(prod_r[2][0]) + 34'(prod_r[2][1]) + 34'(prod_r[2][2]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bx_r  <= bx_nxt;
      by_r  <= by_nxt;
      sum_r <= bx_nxt + by_nxt + bz_nxt;
    end
  end

  assign sum_zero = (sum_r == '0);

  // x and y are below 1.0 whenever the sum is nonzero
  rgbc_div_pipe #(.DW(34), .QW(XY_QW), .SPS(DIV_SPS)) u_div_x (
    .clk     (clk),
    .en      (en[2 +: XY_NS]),
    .rem_in  (bx_r),
    .bits_in ('0),
    .div_in  (sum_r),
    .quo_out (xq)
  );

  rgbc_div_pipe #(.DW(34), .QW(XY_QW), .SPS(DIV_SPS)) u_div_y (
    .clk     (clk),
    .en      (en[2 +: XY_NS]),
    .rem_in  (by_r),
    .bits_in ('0),
    .div_in  (sum_r),
    .quo_out (yq)
  );

endmodule

FILE: rtl/rgbc_mccamy.sv
`timescale 1ns / 1ps
// mccamy cubic: slope division, clamp, powers and cubic accumulation
// depends on rgbc_pkg and rgbc_div_pipe

module rgbc_mccamy (
  input  logic                                clk,
  input  logic [rgbc_pkg::MC_TOT-1:0]         en,
  input  logic [15:0]                         xq,
  input  logic [15:0]                         yq,
  output logic                                den_zero,
  output logic signed [rgbc_pkg::ACC_W-1:0]   acc
);

  import rgbc_pkg::*;

  localparam logic signed [31:0] NUM_OFS = 32'sd217579520;  // 0.3320 times 10000, in q16
  localparam logic signed [31:0] DEN_OFS = 32'sd121765888;  // 0.1858 times 10000, in q16
  localparam int unsigned P1 = 2 + MC_NS;

  logic signed [31:0] num_r, den_r, nabs, dabs;
  logic [29:0] nmag, dmag;
  logic        ovf_nxt;
  logic [29:0] rem0_r, dmag_r;
  logic [20:0] bits_r, quo;
  logic [1:0]  c2_r;              // {negative, overflow}
  logic [1:0]  sb_r [MC_NS];
  logic [20:0] mag1_r, mag2_r, mag3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [24:0] n2_r, n2b_r;
  logic [41:0] sq;
  logic [45:0] cu;
  logic [28:0] n3m_r;
  logic signed [ACC_W-1:0] acc_r, n3s, n2s, ns;

  // numerator and denominator of the slope
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r <= $signed(32'(xq) * 32'd10000) - NUM_OFS;
      den_r <= DEN_OFS - $signed(32'(yq) * 32'd10000);
    end
  end

  assign den_zero = (den_r == '0);

  // sign and magnitude, early overflow check on the quotient
  assign nabs    = num_r[31] ? -num_r : num_r;
  assign dabs    = den_r[31] ? -den_r : den_r;
  assign nmag    = nabs[29:0];
  assign dmag    = dabs[29:0];
  assign ovf_nxt = {5'b0, nmag} >= {dmag, 5'b0};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem0_r <= ovf_nxt ? '0 : {5'b0, nmag[29:5]};
      bits_r <= {nmag[4:0], 16'b0};
      dmag_r <= dmag;
      c2_r   <= {num_r[31] ^ den_r[31], ovf_nxt};
    end
  end

  rgbc_div_pipe #(.DW(30), .QW(MC_QW), .SPS(DIV_SPS)) u_div_n (
    .clk     (clk),
    .en      (en[2 +: MC_NS]),
    .rem_in  (rem0_r),
    .bits_in (bits_r),
    .div_in  (dmag_r),
    .quo_out (quo)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < MC_NS; i++) begin
      if (en[2+i]) sb_r[i] <= (i == 0) ? c2_r : sb_r[(i == 0) ? 0 : i-1];
    end
  end

  // clamp to 16.0
  always_ff @(posedge clk) begin
    if (en[P1]) begin
      mag1_r <= (sb_r[MC_NS-1][0] || quo > 21'h100000) ? 21'h100000 : quo;
      neg1_r <= sb_r[MC_NS-1][1];
    end
  end

  // n squared
  assign sq = 42'(mag1_r) * 42'(mag1_r);

  always_ff @(posedge clk) begin
    if (en[P1+1]) begin
      n2_r   <= sq[40:16];
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  // n cubed, truncated toward zero via magnitude
  assign cu = 46'(n2_r) * 46'(mag2_r);

  always_ff @(posedge clk) begin
    if (en[P1+2]) begin
      n3m_r  <= cu[44:16];
      n2b_r  <= n2_r;
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
    end
  end

  // cubic
  assign n3s = neg3_r ? -$signed({11'b0, n3m_r}) : $signed({11'b0, n3m_r});
  assign n2s = $signed({15'b0, n2b_r});
  assign ns  = neg3_r ? -$signed({19'b0, mag3_r}) : $signed({19'b0, mag3_r});

  always_ff @(posedge clk) begin
    if (en[P1+3]) begin
      acc_r <= 40'sd437 * n3s + 40'sd3601 * n2s + 40'sd6831 * ns + 40'sd361562112;
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/rgbc_thresh.sv
`timescale 1ns / 1ps
// per-sensor threshold table with per-word valid bits cleared at reset
// depends on rgbc_pkg

module rgbc_thresh #(
  parameter int unsigned SENSORS = rgbc_pkg::SENSORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  rgbc_pkg::thr_req_t                  req,
  output logic [rgbc_pkg::SLOTS-1:0][15:0]    thr
);

  import rgbc_pkg::*;

  localparam int unsigned RW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  logic [15:0]      mem [SENSORS][SLOTS];
  logic [SLOTS-1:0] vld_r [SENSORS];
  logic [15:0]      rd_r [SLOTS];
  logic [SLOTS-1:0] rv_r;
  logic [RW-1:0]    row;
  logic             in_rng, wr_ok;

  assign row    = RW'(req.sensor);
  assign in_rng = 32'(req.sensor) < SENSORS;
  assign wr_ok  = req.wr && in_rng && (32'(req.slot) < SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) vld_r[i] <= '0;
    end else if (en && wr_ok) begin
      vld_r[row][req.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr_ok) mem[row][req.slot] <= req.value;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= mem[row];
      rv_r <= in_rng ? vld_r[row] : '0;
    end
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) thr[k] = rv_r[k] ? rd_r[k] : 16'd0;
  end

endmodule

FILE: rtl/rgbc_color_temperature_classifier.sv
`timescale 1ns / 1ps
// throughput: one request per cycle unless out_ready holds a full pipeline; the ratio,
//   xy and slope dividers retire two quotient bits per stage and set most of the pipeline depth
// reset: rst_n synchronous, clears stage valid bits and threshold valid bits,
//   so every threshold reads as zero until written; ready right after reset

module rgbc_color_temperature_classifier #(
  parameter int unsigned SENSORS          = rgbc_pkg::SENSORS_DEF,
  parameter int unsigned GAMMA_TABLE_BITS = rgbc_pkg::GAMMA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbc_pkg::out_item_t out_data
);

  import rgbc_pkg::*;

  // request context traveling beside the datapath
  typedef struct packed {
    logic        op;
    logic [2:0]  sensor;
    logic [2:0]  slot;
    logic [15:0] value;
    logic        err;
    logic [2:0]  sat;    // color at or above clear, ratio is 1.0
  } ctx_t;

  logic [NST-1:0] valid_r;
  logic [NST-1:0] en;
  ctx_t           ctx_r  [ST_OUT];
  ctx_t           ctx_in [ST_OUT];

  logic [15:0]      cnt [3];
  logic [15:0]      quo [3];
  logic [2:0][16:0] lin;
  logic             sum_zero, den_zero;
  logic [15:0]      xq, yq;
  logic signed [ACC_W-1:0] acc;
  thr_req_t         thr_req;
  logic [SLOTS-1:0][15:0] thr;
  out_item_t        out_r, res;

  // stage advance: a stage moves when empty or when its successor moves,
  // so bubbles collapse while the output waits
  always_comb begin
    en[NST-1] = !valid_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) en[i] = !valid_r[i] || en[i+1];
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) valid_r[i] <= (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // context pipeline, error flags are merged where they become known
  always_comb begin
    ctx_in[0].op     = in_data.opcode;
    ctx_in[0].sensor = in_data.sensor_index;
    ctx_in[0].slot   = in_data.threshold_slot;
    ctx_in[0].value  = in_data.threshold_value;
    ctx_in[0].err    = (in_data.clear_count == 16'd0);
    ctx_in[0].sat    = {in_data.blue_count  >= in_data.clear_count,
                        in_data.green_count >= in_data.clear_count,
                        in_data.red_count   >= in_data.clear_count};
    for (int i = 1; i < ST_OUT; i++) begin
      ctx_in[i] = ctx_r[i-1];
      if (i == ST_XYZ + 2) ctx_in[i].err = ctx_r[i-1].err | sum_zero;
      if (i == ST_MC + 1) ctx_in[i].err = ctx_r[i-1].err | den_zero;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ST_OUT; i++) begin
      if (en[i]) ctx_r[i] <= ctx_in[i];
    end
  end

  // color over clear ratio, one divider per channel
  assign cnt[0] = in_data.red_count;
  assign cnt[1] = in_data.green_count;
  assign cnt[2] = in_data.blue_count;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    rgbc_div_pipe #(.DW(16), .QW(RATIO_QW), .SPS(DIV_SPS)) u_ratio (
      .clk     (clk),
      .en      (en[0 +: RATIO_NS]),
      .rem_in  (ctx_in[0].sat[c] ? 16'd0 : cnt[c]),
      .bits_in ('0),
      .div_in  (in_data.clear_count),
      .quo_out (quo[c])
    );

    rgbc_gamma #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_gamma (
      .clk   (clk),
      .en    (en[ST_GAM +: 2]),
      .sat   (ctx_r[ST_GAM-1].sat[c]),
      .ratio (quo[c]),
      .lin   (lin[c])
    );
  end

  // xyz and chromaticity
  rgbc_xyz u_xyz (
    .clk      (clk),
    .en       (en[ST_XYZ +: XYZ_TOT]),
    .lin      (lin),
    .sum_zero (sum_zero),
    .xq       (xq),
    .yq       (yq)
  );

  // mccamy cubic
  rgbc_mccamy u_mccamy (
    .clk      (clk),
    .en       (en[ST_MC +: MC_TOT]),
    .xq       (xq),
    .yq       (yq),
    .den_zero (den_zero),
    .acc      (acc)
  );

  // threshold writes and reads share one stage, so request order is kept
  always_comb begin
    thr_req.wr     = valid_r[ST_OUT-2] && (ctx_r[ST_OUT-2].op == OP_WRITE);
    thr_req.sensor = ctx_r[ST_OUT-2].sensor;
    thr_req.slot   = ctx_r[ST_OUT-2].slot;
    thr_req.value  = ctx_r[ST_OUT-2].value;
  end

  rgbc_thresh #(.SENSORS(SENSORS)) u_thresh (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en[ST_OUT-1]),
    .req   (thr_req),
    .thr   (thr)
  );

  // saturate the temperature and classify against open windows
  always_comb begin
    logic [15:0] cct;
    if (acc <= 0) cct = 16'd0;
    else if (acc[ACC_W-1:32] != '0) cct = 16'hFFFF;
    else cct = acc[31:16];

    res = '0;
    if (ctx_r[ST_OUT-1].op == OP_WRITE) begin
      res = '0;
    end else if (ctx_r[ST_OUT-1].err) begin
      res.math_error = 1'b1;
    end else begin
      res.cct_kelvin = cct;
      if (cct > thr[SLOT_MID_MIN] && cct < thr[SLOT_MID_MAX])
        res.color_class = CLS_MID;
      else if (cct > thr[SLOT_WHITE_MIN] && cct < thr[SLOT_WHITE_MAX])
        res.color_class = CLS_WHITE;
      else if (cct > thr[SLOT_YELLOW_MIN] && cct < thr[SLOT_YELLOW_MAX])
        res.color_class = CLS_YELLOW;
      else
        res.color_class = CLS_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) out_r <= res;
  end

  assign out_valid = valid_r[ST_OUT];
  assign out_data  = out_r;

  // write requests produce an all-zero result
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_OUT-1] && en[ST_OUT] && ctx_r[ST_OUT-1].op == OP_WRITE |=>
      out_data.cct_kelvin == 16'd0 && out_data.color_class == CLS_NONE &&
      !out_data.math_error)
    else $error("write request gave a nonzero result");

  // a math error carries no temperature or class
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.math_error |->
      out_data.cct_kelvin == 16'd0 && out_data.color_class == CLS_NONE)
    else $error("math error with temperature or class");

  // inside an open window the temperature is above zero
  a_class_cct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.color_class != CLS_NONE |-> out_data.cct_kelvin != 16'd0)
    else $error("class set with zero temperature");

  // back pressure only when the first stage holds a request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> valid_r[0])
    else $error("not ready with an empty first stage");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of rgbc_color_temperature_classifier: a behavioral model of the
// gamma, xyz, mccamy and window logic predicts every result; depends on rgbc_pkg and the rtl

module testbench;
  import rgbc_pkg::*;

  localparam int NSENS       = 8;
  localparam int GBITS       = 10;
  localparam int GSTEPS      = 1 << GBITS;
  localparam int FBITS       = 16 - GBITS;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // predictor state: threshold words and the gamma curve samples
  logic [15:0]       thr_words[NSENS*SLOTS];
  longint unsigned   gamma_curve[GSTEPS+1];
  out_item_t         pending_results[$];

  int  mismatches;
  int  requests_sent;
  int  results_seen;
  int  class_hits[4];
  int  error_hits;
  int  idle_cycles;
  bit  idling_on;
  int  hold_left;
  int  burst_left;

  rgbc_color_temperature_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------

  // r^5 in q16, each product truncated
  function automatic longint unsigned pow5_q16(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int k = 0; k < 4; k++) p = (p * r) >> 16;
    return p;
  endfunction

  // srgb to linear for one ratio; the power part is found by bisection on t^0.4
  function automatic longint unsigned srgb_to_linear(longint unsigned s);
    longint unsigned t, t2, lo, hi, mid;
    if (s * 100000 <= 64'd4045 * 65536) return (s * 100) / 1292;
    t  = (s * 1000 + 55 * 65536) / 1055;
    t2 = (t * t) >> 16;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (pow5_q16(mid) <= t2) lo = mid;
      else hi = mid - 1;
    end
    return (t2 * lo) >> 16;
  endfunction

  // count over clear, saturated at one, then interpolated between curve samples
  function automatic longint unsigned channel_linear(longint unsigned cnt,
                                                    longint unsigned clr);
    longint unsigned s, i, f;
    s = (cnt << 16) / clr;
    if (s >= 65536) return 65536;
    i = s >> FBITS;
    f = s & ((1 << FBITS) - 1);
    return (gamma_curve[i] * ((1 << FBITS) - f) + gamma_curve[i+1] * f) >> FBITS;
  endfunction

  function automatic bit in_open_window(logic [15:0] v, logic [15:0] mx, logic [15:0] mn);
    return (v > mn) && (v < mx);
  endfunction

  // expected result of one request; writes also update the threshold copy
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t       res;
    longint unsigned lr, lg, lb, bx, by, bz, sum, xq, yq;
    longint          num, den, n, n2, n3, acc, c;
    int              base;
    res = '0;
    if (req.opcode == OP_WRITE) begin
      if (req.threshold_slot < SLOTS)
        thr_words[req.sensor_index*SLOTS + req.threshold_slot] = req.threshold_value;
      return res;
    end
    // no light at all on the clear channel
    if (req.clear_count == 0) begin
      res.math_error = 1'b1;
      return res;
    end
    lr  = channel_linear(req.red_count, req.clear_count);
    lg  = channel_linear(req.green_count, req.clear_count);
    lb  = channel_linear(req.blue_count, req.clear_count);
    bx  = 27031 * lr + 23434 * lg + 11825 * lb;
    by  = 13938 * lr + 46868 * lg + 4730 * lb;
    bz  = 1267 * lr + 7811 * lg + 62279 * lb;
    sum = bx + by + bz;
    // black sample: chromaticity undefined
    if (sum == 0) begin
      res.math_error = 1'b1;
      return res;
    end
    xq  = (bx << 16) / sum;
    yq  = (by << 16) / sum;
    num = longint'(xq) * 10000 - longint'(3320) * 65536;
    den = longint'(1858) * 65536 - longint'(yq) * 10000;
    if (den == 0) begin
      res.math_error = 1'b1;
      return res;
    end
    n = (num * 65536) / den;
    if (n > 16 * 65536) n = 16 * 65536;
    if (n < -16 * 65536) n = -16 * 65536;
    n2  = (n * n) >>> 16;
    n3  = (n2 * n) / 65536;
    acc = 437 * n3 + 3601 * n2 + 6831 * n + longint'(5517) * 65536;
    if (acc <= 0) c = 0;
    else c = acc >>> 16;
    res.cct_kelvin = (c > 65535) ? 16'hffff : c[15:0];
    base = req.sensor_index * SLOTS;
    if (in_open_window(res.cct_kelvin, thr_words[base+SLOT_MID_MAX], thr_words[base+SLOT_MID_MIN]))
      res.color_class = CLS_MID;
    else if (in_open_window(res.cct_kelvin, thr_words[base+SLOT_WHITE_MAX],
                            thr_words[base+SLOT_WHITE_MIN]))
      res.color_class = CLS_WHITE;
    else if (in_open_window(res.cct_kelvin, thr_words[base+SLOT_YELLOW_MAX],
                            thr_words[base+SLOT_YELLOW_MIN]))
      res.color_class = CLS_YELLOW;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // accept monitor, result checker, receiver stalls, watchdog
  // ---------------------------------------------------------------------------

  // a request counts when valid and ready are both high at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(predict_result(in_data));
      requests_sent++;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, cct", out_data.cct_kelvin, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.cct_kelvin !== want.cct_kelvin)
          report_mismatch("cct_kelvin", out_data.cct_kelvin, want.cct_kelvin);
        if (out_data.color_class !== want.color_class)
          report_mismatch("color_class", out_data.color_class, want.color_class);
        if (out_data.math_error !== want.math_error)
          report_mismatch("math_error", out_data.math_error, want.math_error);
        class_hits[want.color_class]++;
        if (want.math_error) error_hits++;
      end
    end
  end

  // receiver: a long hold when asked for, otherwise random stall bursts
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b1;
    if (!rst_n) begin
      nxt = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      nxt = 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(1, 14) - 1;
      nxt = 1'b0;
    end
    out_ready <= nxt;
  end

  // ends the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offers one request and returns once it has been taken
  task automatic send_request(in_item_t req);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t classify_req(logic [2:0] sensor, logic [15:0] r,
                                            logic [15:0] g, logic [15:0] b,
                                            logic [15:0] c);
    in_item_t req;
    req                 = '0;
    req.opcode          = OP_CLASSIFY;
    req.sensor_index    = sensor;
    req.red_count       = r;
    req.green_count     = g;
    req.blue_count      = b;
    req.clear_count     = c;
    req.threshold_slot  = 3'($urandom);
    req.threshold_value = 16'($urandom);
    return req;
  endfunction

  function automatic in_item_t write_req(logic [2:0] sensor, logic [2:0] slot,
                                         logic [15:0] value);
    in_item_t req;
    req                 = in_item_t'({$urandom, $urandom, $urandom});
    req.opcode          = OP_WRITE;
    req.sensor_index    = sensor;
    req.threshold_slot  = slot;
    req.threshold_value = value;
    return req;
  endfunction

  // random sample: mostly colors at or under clear, some above, some dark or blank
  function automatic in_item_t random_sample();
    logic [15:0] c;
    logic [15:0] lim;
    int          mode;
    mode = $urandom_range(0, 19);
    case (mode)
      0:       c = 16'd0;
      1, 2:    c = 16'hffff;
      3, 4:    c = 16'($urandom_range(1, 255));
      default: c = 16'($urandom_range(1, 65535));
    endcase
    if (mode == 5) return classify_req(3'($urandom), 16'd0, 16'd0, 16'd0, c);
    if (mode >= 17) begin
      return classify_req(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), c);
    end
    lim = c;
    return classify_req(3'($urandom), 16'($urandom_range(0, lim)),
                        16'($urandom_range(0, lim)), 16'($urandom_range(0, lim)), c);
  endfunction

  // random window set so that all three classes and misses occur
  task automatic load_random_windows(logic [2:0] sensor);
    int lo;
    for (int w = 0; w < 3; w++) begin
      lo = $urandom_range(0, 9000);
      send_request(write_req(sensor, 3'(2*w + 1), 16'(lo)));
      send_request(write_req(sensor, 3'(2*w), 16'(lo + $urandom_range(0, 12000))));
    end
  endtask

  // extremes, every opcode and each special case
  task automatic test_directed();
    send_request(classify_req(3'd0, 16'd100, 16'd100, 16'd100, 16'd0));    // dark clear
    send_request(classify_req(3'd1, 16'd0, 16'd0, 16'd0, 16'd500));        // black sample
    send_request(classify_req(3'd2, 16'hffff, 16'hffff, 16'hffff, 16'd1)); // colors above clear
    send_request(classify_req(3'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_request(classify_req(3'd4, 16'hffff, 16'd0, 16'd0, 16'hffff));    // pure red
    send_request(classify_req(3'd5, 16'd0, 16'd0, 16'hffff, 16'hffff));    // pure blue
    send_request(classify_req(3'd6, 16'd0, 16'hffff, 16'd0, 16'hffff));    // pure green
    send_request(classify_req(3'd7, 16'd1, 16'd1, 16'd1, 16'hffff));       // linear segment
    // windows on sensor 0 with the extremes of the threshold word
    send_request(write_req(3'd0, SLOT_MID_MAX, 16'd5000));
    send_request(write_req(3'd0, SLOT_MID_MIN, 16'd0));
    send_request(write_req(3'd0, SLOT_WHITE_MAX, 16'hffff));
    send_request(write_req(3'd0, SLOT_WHITE_MIN, 16'd4000));
    send_request(write_req(3'd0, SLOT_YELLOW_MAX, 16'hffff));
    send_request(write_req(3'd0, SLOT_YELLOW_MIN, 16'd0));
    send_request(write_req(3'd0, 3'd6, 16'd1));                            // slots past the set
    send_request(write_req(3'd0, 3'd7, 16'd1));
    send_request(classify_req(3'd0, 16'd30000, 16'd20000, 16'd8000, 16'd60000)); // warm
    send_request(classify_req(3'd0, 16'd20000, 16'd25000, 16'd30000, 16'd60000)); // cool
    send_request(classify_req(3'd0, 16'd0, 16'd0, 16'hffff, 16'hffff));
    send_request(classify_req(3'd0, 16'hffff, 16'd0, 16'd0, 16'hffff));
  endtask

  // random windows and samples, the bulk of the run
  task automatic test_random_mix(int n_items);
    for (int s = 0; s < NSENS; s++) load_random_windows(3'(s));
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(write_req(3'($urandom), 3'($urandom), 16'($urandom)));
      else
        send_request(random_sample());
    end
  endtask

  // receiver holds off long enough that the pipeline fills and in_ready drops
  task automatic test_backpressure();
    hold_left = 120;
    for (int k = 0; k < 60; k++) send_request(random_sample());
  endtask

  // sender pauses until every pending result has come back
  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) send_request(random_sample());
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    for (int k = 0; k < 10; k++) send_request(random_sample());
  endtask

  // no idling at all: back to back requests and an always-ready receiver
  task automatic test_full_rate();
    idling_on = 1'b0;
    for (int k = 0; k < 40; k++) send_request(random_sample());
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b1;
    idling_on  = 1'b1;
    hold_left  = 0;
    burst_left = 0;
    mismatches = 0;
    idle_cycles = 0;
    for (int i = 0; i < NSENS*SLOTS; i++) thr_words[i] = '0;
    for (int i = 0; i <= GSTEPS; i++) gamma_curve[i] = srgb_to_linear(longint'(i) << FBITS);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(380);
    test_backpressure();
    test_drain_pause();
    test_full_rate();

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d requests and %0d results: none %0d, middle %0d, white %0d, yellow %0d",
             requests_sent, results_seen, class_hits[CLS_NONE], class_hits[CLS_MID],
             class_hits[CLS_WHITE], class_hits[CLS_YELLOW]);
    $display("math errors %0d, mismatches %0d", error_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
